// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL, included by insertion_sorter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/isrt_pkg.sv =====
`timescale 1ns / 1ps

package isrt_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 6;
  localparam int CAPACITY_DEF = 64;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
  } cell_t;

  typedef struct packed {
    logic ins_en;    // insert the broadcast value
    logic shift_en;  // move every entry one cell toward the head
  } chain_cmd_t;

  typedef struct packed {
    cell_t head;
    logic  second_valid;
    logic  full;
  } chain_stat_t;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_t;

endpackage

// ===== design/isrt_if.sv =====
`timescale 1ns / 1ps

interface isrt_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [isrt_pkg::DATA_W-1:0] value;
  logic                                last_in;

  modport source (output valid, value, last_in, input ready);
  modport sink   (input valid, value, last_in, output ready);
endinterface

interface isrt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [isrt_pkg::DATA_W-1:0] sorted_value;
  logic        [isrt_pkg::POS_W-1:0]  position;
  logic                                last_out;
  logic                                overflowed;

  modport source (output valid, sorted_value, position, last_out, overflowed, input ready);
  modport sink   (input valid, sorted_value, position, last_out, overflowed, output ready);
endinterface

// ===== design/isrt_cell.sv =====
`timescale 1ns / 1ps

module isrt_cell import isrt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  chain_cmd_t               cmd,
  input  logic signed [DATA_W-1:0] new_value,
  input  cell_t                    prev_cell,
  input  logic                     prev_ins,
  input  cell_t                    next_cell,
  output cell_t                    cell_q,
  output logic                     ins
);

  cell_t cell_r;
  cell_t cell_nxt;

  // Empty cell or strictly larger entry: the new value belongs here or before.
  assign ins = !cell_r.valid || ($signed(cell_r.value) > $signed(new_value));

  always_comb begin
    cell_nxt = cell_r;
    if (cmd.shift_en) begin
      cell_nxt = next_cell;
    end else if (cmd.ins_en) begin
      if (prev_ins) begin
        cell_nxt = prev_cell;
      end else if (ins) begin
        cell_nxt.valid = 1'b1;
        cell_nxt.value = new_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_nxt.valid;
    end
    cell_r.value <= cell_nxt.value;
  end

  assign cell_q = cell_r;

endmodule

// ===== design/isrt_chain.sv =====
`timescale 1ns / 1ps

module isrt_chain import isrt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  chain_cmd_t               cmd,
  input  logic signed [DATA_W-1:0] new_value,
  output chain_stat_t              stat
);

  cell_t cells [CAPACITY];
  logic  ins   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_t prev_c;
    cell_t next_c;
    logic  prev_i;

    if (i == 0) begin : g_head
      assign prev_c = '0;
      assign prev_i = 1'b0;
    end else begin : g_body
      assign prev_c = cells[i-1];
      assign prev_i = ins[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_c = '0;
    end else begin : g_inner
      assign next_c = cells[i+1];
    end

    isrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .new_value (new_value),
      .prev_cell (prev_c),
      .prev_ins  (prev_i),
      .next_cell (next_c),
      .cell_q    (cells[i]),
      .ins       (ins[i])
    );
  end

  assign stat.head         = cells[0];
  assign stat.second_valid = cells[1].valid;
  assign stat.full         = cells[CAPACITY-1].valid;

endmodule

// ===== design/insertion_sorter.sv =====
// Streaming stable insertion sorter for signed 32-bit values.
// in_ch carries value and last_in; out_ch carries sorted_value, position,
// last_out and overflowed. Both are valid/ready channels.
// While collecting, one value is taken every cycle and inserted in the same
// cycle: every cell compares against it in parallel and larger entries move
// one cell down. Values arriving with the store full are dropped and every
// result of that set reports overflowed.
// The request with last_in closes the set. in_ch.ready then drops and the
// chain shifts toward its head, one result per cycle while out_ch.ready
// allows it, positions from 0 and last_out on the final one. The first
// result is loaded once the controller is in ST_EMIT and the output register
// is free, that is empty or being taken by the receiver.
// When out_ch.ready is low, the output register holds its result and the
// chain stops shifting; nothing is lost. Collecting resumes the cycle after
// the final result is loaded, even if that result is still waiting.
// Reset (rst_n low, synchronous) empties the chain, clears the drop flag and
// the output valid; stored values are not cleared and need no sweep.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module insertion_sorter import isrt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  isrt_in_if.sink     in_ch,
  isrt_out_if.source  out_ch
);

  state_t      state_r, state_nxt;
  chain_cmd_t  cmd;
  chain_stat_t stat;

  logic                     in_acc;
  logic                     load_en;
  logic                     load_last;
  logic                     drop_r, drop_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r;
  logic [POS_W-1:0]         out_pos_r;
  logic                     out_last_r;
  logic                     out_ovf_r;

  isrt_chain #(.CAPACITY(CAPACITY)) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .new_value (in_ch.value),
    .stat      (stat)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_COLLECT: if (in_acc && in_ch.last_in) state_nxt = ST_EMIT;
      ST_EMIT:    if (load_last) state_nxt = ST_COLLECT;
      default:    state_nxt = ST_COLLECT;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    in_ch.ready  = 1'b0;
    load_en      = 1'b0;
    case (state_r)
      ST_COLLECT: in_ch.ready = 1'b1;
      ST_EMIT:    load_en = !out_valid_r || out_ch.ready;
      default:    in_ch.ready = 1'b0;
    endcase
  end

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign load_last    = load_en && !stat.second_valid;
  assign cmd.ins_en   = in_acc && !stat.full;
  assign cmd.shift_en = load_en;

  always_comb begin
    drop_nxt = drop_r;
    pos_nxt  = pos_r;
    if (in_acc && stat.full) drop_nxt = 1'b1;
    if (load_en) begin
      pos_nxt = pos_r + 1'b1;
      if (load_last) begin
        pos_nxt  = '0;
        drop_nxt = 1'b0;
      end
    end
    out_valid_nxt = out_valid_r;
    if (load_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      drop_r      <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drop_r      <= drop_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      out_value_r <= stat.head.value;
      out_pos_r   <= pos_r;
      out_last_r  <= !stat.second_valid;
      out_ovf_r   <= drop_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_value_r;
  assign out_ch.position     = out_pos_r;
  assign out_ch.last_out     = out_last_r;
  assign out_ch.overflowed   = out_ovf_r;

  `ASSERT_CLK(a_close_to_emit, (in_acc && in_ch.last_in) |=> (state_r == ST_EMIT), "closing request did not start emission")
  `ASSERT_CLK(a_emit_has_data, (state_r == ST_EMIT) |-> stat.head.valid, "emission with empty chain")
  `ASSERT_CLK(a_last_empties, load_last |=> !stat.head.valid, "chain not empty after final result")
  `ASSERT_NEVER(a_drop_only_full, cmd.ins_en && stat.full, "insert into full chain")

endmodule
